### design/ssl_pkg.sv
`timescale 1ns / 1ps

package ssl_pkg;

    // defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int TANH_DEPTH_DEF   = 256;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MIX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TONE  = 2'd2;

    localparam logic [CFG_W-1:0] MIX_RESET   = 16'd32768;
    localparam logic [CFG_W-1:0] DRIVE_RESET = 16'd13107;
    localparam logic [CFG_W-1:0] TONE_RESET  = 16'd45875;

    // shared multiplier: signed A, unsigned B
    localparam int MA_W = 28;
    localparam int MB_W = 26;
    localparam int P_W  = MA_W + MB_W + 1;

    // tanh table entry, Q1.23 magnitude
    localparam int TAB_W = 24;

    typedef struct packed {
        logic [CFG_W-1:0] mix;
        logic [CFG_W-1:0] drive;
        logic [CFG_W-1:0] tone;
    } ssl_cfg_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ssl_stat_t;

endpackage

### design/stereo_saturation_lowpass_mix.sv
`timescale 1ns / 1ps

// Stereo tanh soft clipper with a one-pole lowpass and dry/wet mix. Each input
// beat is one stereo frame (left_in, right_in, block_end_in); each output beat is
// the matching mixed frame, block_end_out a copy of the input mark. Per channel
// the sample is scaled by 1 + 12*drive_level/65536, clipped through an
// interpolated tanh table, filtered by a one-pole lowpass whose coefficient is
// 0.02 + 0.35*tone_level/65536, blended with the dry sample by mix_level/65536
// and saturated. Both filter states start at zero after reset. Registers are
// written through cfg_write/cfg_index/cfg_data, by the user only while no frame is
// in flight (not enforced by the block): index 0 mix_level, 1 drive_level,
// 2 tone_level, other indexes are dropped. A frame occupies the sequencer from its
// accepting beat until its result sits in the output register, so a frame is
// taken only after the last is handed over. The single shared multiplier is
// used six times per channel plus once for the filter coefficient: two sequencer
// steps for the coefficient, fifteen per channel including the table reads, and
// one to hand the result over. in_stall is high while the sequencer works; the
// output register lets the next frame start while a finished result waits.
module stereo_saturation_lowpass_mix import ssl_pkg::*;
#(
    parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
    parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    // configuration writes
    input  logic                           cfg_write,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,

    // input frames
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] left_in,
    input  logic signed [SAMPLE_WIDTH-1:0] right_in,
    input  logic                           block_end_in,

    // output frames
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] left_out,
    output logic signed [SAMPLE_WIDTH-1:0] right_out,
    output logic                           block_end_out
);

    logic [CFG_W-1:0] mix_reg, mix_next;
    logic [CFG_W-1:0] drive_reg, drive_next;
    logic [CFG_W-1:0] tone_reg, tone_next;

    logic out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] left_out_reg, left_out_next;
    logic signed [SAMPLE_WIDTH-1:0] right_out_reg, right_out_next;
    logic                           bend_out_reg, bend_out_next;

    ssl_cfg_t  cfg;
    ssl_stat_t core_stat;
    logic      start;
    logic      load;
    logic signed [SAMPLE_WIDTH-1:0] left_res;
    logic signed [SAMPLE_WIDTH-1:0] right_res;
    logic                           bend_res;

    assign cfg.mix   = mix_reg;
    assign cfg.drive = drive_reg;
    assign cfg.tone  = tone_reg;

    // a frame enters only while the sequencer is idle
    assign in_stall = !core_stat.idle;
    assign start    = in_valid && !in_stall;

    // finished frame moves to the output register when it is free or draining
    assign load = core_stat.done && (!out_valid_reg || !out_stall);

    ssl_core #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .ack           (load),
        .cfg           (cfg),
        .left_smp      (left_in),
        .right_smp     (right_in),
        .block_end     (block_end_in),
        .stat          (core_stat),
        .left_res      (left_res),
        .right_res     (right_res),
        .block_end_res (bend_res)
    );

    // register file; unknown indexes fall through
    always_comb
    begin
        mix_next   = mix_reg;
        drive_next = drive_reg;
        tone_next  = tone_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_MIX:   mix_next   = cfg_data;
                REG_DRIVE: drive_next = cfg_data;
                REG_TONE:  tone_next  = cfg_data;
                default:   mix_next   = mix_reg;
            endcase
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        bend_out_next  = bend_out_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            left_out_next  = left_res;
            right_out_next = right_res;
            bend_out_next  = bend_res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_reg       <= MIX_RESET;
            drive_reg     <= DRIVE_RESET;
            tone_reg      <= TONE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mix_reg       <= mix_next;
            drive_reg     <= drive_next;
            tone_reg      <= tone_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        bend_out_reg  <= bend_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign left_out      = left_out_reg;
    assign right_out     = right_out_reg;
    assign block_end_out = bend_out_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted frame did not occupy the sequencer");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (core_stat.done && out_valid_reg && out_stall) |=> core_stat.done)
        else $error("finished frame dropped while output stalled");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (core_stat.done && !out_valid_reg) |=> (out_valid_reg && !core_stat.done))
        else $error("finished frame not moved to empty output register");
`endif

endmodule

### design/ssl_mul.sv
`timescale 1ns / 1ps

// shared signed x unsigned multiplier, product registered
module ssl_mul import ssl_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [MA_W-1:0] op_a,
    input  logic        [MB_W-1:0] op_b,
    output logic signed [P_W-1:0]  prod_reg
);

    logic signed [P_W-1:0] prod_next;

    assign prod_next = op_a * $signed({1'b0, op_b});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

### design/ssl_tanh_rom.sv
`timescale 1ns / 1ps

// tanh over [0, 8], DEPTH+1 points, registered read
module ssl_tanh_rom import ssl_pkg::*;
#(
    parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF,
    parameter int AW               = $clog2(TANH_TABLE_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic [AW-1:0]    addr,
    output logic [TAB_W-1:0] data_reg
);

    localparam logic [63:0] Q30 = 64'd1 << 30;

    // restoring division, elaboration only
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], num[i]};
            if (r >= den)
            begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-a) by series, squared six times, then (1-e)/(1+e)
    function automatic logic [TAB_W-1:0] tanh_entry(input int k);
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] den;
        a    = udiv((64'(k) << 28) + 64'(TANH_TABLE_DEPTH >> 1), 64'(TANH_TABLE_DEPTH));
        term = Q30;
        sum  = Q30;
        for (int n = 1; n <= 12; n++)
        begin
            term = udiv((term * a) >> 30, 64'(n));
            if ((n & 1) != 0)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        for (int n = 0; n < 6; n++)
        begin
            sum = (sum * sum + (Q30 >> 1)) >> 30;
        end
        if (sum > Q30)
        begin
            sum = Q30;
        end
        den = Q30 + sum;
        return TAB_W'(udiv(((Q30 - sum) << 23) + (den >> 1), den));
    endfunction

    logic [TAB_W-1:0] rom [TANH_TABLE_DEPTH+1];

    for (genvar k = 0; k <= TANH_TABLE_DEPTH; k++)
    begin : g_rom
        localparam logic [TAB_W-1:0] ENTRY = tanh_entry(k);
        assign rom[k] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom[addr];
    end

endmodule

### design/ssl_core.sv
`timescale 1ns / 1ps

// per-frame sequencer and datapath around the shared multiplier
module ssl_core import ssl_pkg::*;
#(
    parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
    parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           ack,
    input  ssl_cfg_t                       cfg,
    input  logic signed [SAMPLE_WIDTH-1:0] left_smp,
    input  logic signed [SAMPLE_WIDTH-1:0] right_smp,
    input  logic                           block_end,
    output ssl_stat_t                      stat,
    output logic signed [SAMPLE_WIDTH-1:0] left_res,
    output logic signed [SAMPLE_WIDTH-1:0] right_res,
    output logic                           block_end_res
);

    localparam int XQ_W     = 24;
    localparam int XQ_SHIFT = XQ_W - SAMPLE_WIDTH;
    localparam int GAIN_W   = 20;
    localparam int ARG_W    = 28;
    localparam int MAG_W    = 27;
    localparam int FRAC_W   = 26;
    localparam int COEF_W   = 23;
    localparam int DIF_W    = 25;
    localparam int ACC_W    = 41;
    localparam int MIX_W    = 42;
    localparam int IDX_W    = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int T_W      = MAG_W + IDX_W;
    localparam int IDXF_W   = T_W - FRAC_W;
    localparam int MIX_SH   = 16 + XQ_W - SAMPLE_WIDTH;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 20'd65536;
    localparam logic [COEF_W-1:0] LP_BASE  = 23'd335544;
    localparam logic [MB_W-1:0]   LP_SPAN  = 26'd5872026;
    localparam logic [16:0]       DRY_ONE  = 17'd65536;
    localparam logic [IDX_W-1:0]  IDX_TOP  = IDX_W'(TANH_TABLE_DEPTH);

    localparam logic signed [25:0] STATE_MAX = 26'sd8388607;
    localparam logic signed [25:0] STATE_MIN = -26'sd8388608;

    localparam logic signed [MIX_W-1:0] MIX_RND = MIX_W'(64'd1 << (MIX_SH - 1));
    localparam logic signed [MIX_W-1:0] OUT_HI  = MIX_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
    localparam logic signed [MIX_W-1:0] OUT_LO  = ~OUT_HI;

    // sequencer codes
    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_COEF_MUL = 5'd1;
    localparam logic [4:0] ST_COEF     = 5'd2;
    localparam logic [4:0] ST_ARG_MUL  = 5'd3;
    localparam logic [4:0] ST_ARG      = 5'd4;
    localparam logic [4:0] ST_IDX_MUL  = 5'd5;
    localparam logic [4:0] ST_IDX      = 5'd6;
    localparam logic [4:0] ST_TAB_A    = 5'd7;
    localparam logic [4:0] ST_TAB_B    = 5'd8;
    localparam logic [4:0] ST_DIFF     = 5'd9;
    localparam logic [4:0] ST_INT_MUL  = 5'd10;
    localparam logic [4:0] ST_WET      = 5'd11;
    localparam logic [4:0] ST_LPD      = 5'd12;
    localparam logic [4:0] ST_LP_MUL   = 5'd13;
    localparam logic [4:0] ST_LP       = 5'd14;
    localparam logic [4:0] ST_DRY_MUL  = 5'd15;
    localparam logic [4:0] ST_WET_MUL  = 5'd16;
    localparam logic [4:0] ST_MIX      = 5'd17;
    localparam logic [4:0] ST_DONE     = 5'd18;

    logic [4:0] state_reg, state_next;
    logic       ch_reg, ch_next;

    logic signed [XQ_W-1:0]         lp_reg [2];
    logic signed [XQ_W-1:0]         lp_next [2];
    logic signed [SAMPLE_WIDTH-1:0] res_reg [2];
    logic signed [SAMPLE_WIDTH-1:0] res_next [2];

    logic signed [SAMPLE_WIDTH-1:0] left_reg, left_next;
    logic signed [SAMPLE_WIDTH-1:0] right_reg, right_next;
    logic                           bend_reg, bend_next;
    logic [COEF_W-1:0]              coeff_reg, coeff_next;
    logic                           neg_reg, neg_next;
    logic [MAG_W-1:0]               mag_reg, mag_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [FRAC_W-1:0]              frac_reg, frac_next;
    logic [TAB_W-1:0]               a_reg, a_next;
    logic signed [DIF_W-1:0]        diff_reg, diff_next;
    logic signed [XQ_W-1:0]         wet_reg, wet_next;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;

    logic                    mul_en;
    logic signed [MA_W-1:0]  op_a;
    logic [MB_W-1:0]         op_b;
    logic signed [P_W-1:0]   prod_reg;
    logic [IDX_W-1:0]        rom_addr;
    logic [TAB_W-1:0]        rom_data;

    logic signed [XQ_W-1:0]  xq;
    logic signed [XQ_W-1:0]  lp_cur;
    logic [GAIN_W-1:0]       gain;
    logic [16:0]             dry_w;
    logic [38:0]             cf_sum;
    logic signed [43:0]      arg_sum;
    logic signed [ARG_W-1:0] arg_val;
    logic [MAG_W-1:0]        mag_val;
    logic [T_W-1:0]          t_val;
    logic [IDXF_W-1:0]       idx_full;
    logic [IDX_W-1:0]        idx_b;
    logic signed [50:0]      int_sum;
    logic signed [24:0]      y_val;
    logic signed [XQ_W-1:0]  wet_val;
    logic signed [DIF_W-1:0] lpd_val;
    logic signed [47:0]      lp_sum;
    logic signed [25:0]      s_val;
    logic signed [XQ_W-1:0]  s_clamp;
    logic signed [MIX_W-1:0] mix_sum;
    logic signed [MIX_W-1:0] mix_val;
    logic signed [SAMPLE_WIDTH-1:0] res_val;

    ssl_mul u_mul
    (
        .clk      (clk),
        .en       (mul_en),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    ssl_tanh_rom #(
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH),
        .AW               (IDX_W)
    ) u_rom
    (
        .clk      (clk),
        .addr     (rom_addr),
        .data_reg (rom_data)
    );

    // datapath arithmetic on the registered product
    always_comb
    begin
        xq       = ch_reg ? (XQ_W'(right_reg) <<< XQ_SHIFT) : (XQ_W'(left_reg) <<< XQ_SHIFT);
        lp_cur   = lp_reg[ch_reg];
        gain     = GAIN_ONE + GAIN_W'({cfg.drive, 3'b000}) + GAIN_W'({cfg.drive, 2'b00});
        dry_w    = DRY_ONE - {1'b0, cfg.mix};

        cf_sum   = prod_reg[38:0] + 39'd32768;
        arg_sum  = $signed(prod_reg[43:0]) + 44'sd32768;
        arg_val  = $signed(arg_sum[43:16]);
        mag_val  = arg_val[ARG_W-1] ? MAG_W'(-arg_val) : arg_val[MAG_W-1:0];
        t_val    = prod_reg[T_W-1:0];
        idx_full = t_val[T_W-1:FRAC_W];
        idx_b    = (idx_reg == IDX_TOP) ? idx_reg : idx_reg + 1'b1;

        int_sum  = $signed(prod_reg[50:0]) + 51'sd33554432;
        y_val    = $signed({1'b0, a_reg}) + $signed(int_sum[50:26]);
        wet_val  = neg_reg ? XQ_W'(-y_val) : y_val[XQ_W-1:0];
        lpd_val  = DIF_W'(wet_reg) - DIF_W'(lp_cur);

        lp_sum   = $signed(prod_reg[47:0]) + 48'sd8388608;
        s_val    = 26'(lp_cur) + 26'($signed(lp_sum[47:24]));
        if (s_val > STATE_MAX)
        begin
            s_clamp = STATE_MAX[XQ_W-1:0];
        end
        else if (s_val < STATE_MIN)
        begin
            s_clamp = STATE_MIN[XQ_W-1:0];
        end
        else
        begin
            s_clamp = s_val[XQ_W-1:0];
        end

        mix_sum  = MIX_W'(acc_reg) + MIX_W'($signed(prod_reg[39:0])) + MIX_RND;
        mix_val  = mix_sum >>> MIX_SH;
        if (mix_val > OUT_HI)
        begin
            res_val = OUT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (mix_val < OUT_LO)
        begin
            res_val = OUT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            res_val = mix_val[SAMPLE_WIDTH-1:0];
        end
    end

    // multiplier operand select and table address
    always_comb
    begin
        mul_en   = 1'b0;
        op_a     = '0;
        op_b     = '0;
        rom_addr = (state_reg == ST_TAB_B) ? idx_b : idx_reg;
        case (state_reg)
            ST_COEF_MUL:
            begin
                mul_en = 1'b1;
                op_a   = MA_W'(cfg.tone);
                op_b   = LP_SPAN;
            end
            ST_ARG_MUL:
            begin
                mul_en = 1'b1;
                op_a   = MA_W'(xq);
                op_b   = MB_W'(gain);
            end
            ST_IDX_MUL:
            begin
                mul_en = 1'b1;
                op_a   = {1'b0, mag_reg};
                op_b   = MB_W'(TANH_TABLE_DEPTH);
            end
            ST_INT_MUL:
            begin
                mul_en = 1'b1;
                op_a   = MA_W'(diff_reg);
                op_b   = frac_reg;
            end
            ST_LP_MUL:
            begin
                mul_en = 1'b1;
                op_a   = MA_W'(diff_reg);
                op_b   = MB_W'(coeff_reg);
            end
            ST_DRY_MUL:
            begin
                mul_en = 1'b1;
                op_a   = MA_W'(xq);
                op_b   = MB_W'(dry_w);
            end
            ST_WET_MUL:
            begin
                mul_en = 1'b1;
                op_a   = MA_W'(lp_cur);
                op_b   = MB_W'(cfg.mix);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        lp_next    = lp_reg;
        res_next   = res_reg;
        left_next  = left_reg;
        right_next = right_reg;
        bend_next  = bend_reg;
        coeff_next = coeff_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        idx_next   = idx_reg;
        frac_next  = frac_reg;
        a_next     = a_reg;
        diff_next  = diff_reg;
        wet_next   = wet_reg;
        acc_next   = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_COEF_MUL;
                    ch_next    = 1'b0;
                    left_next  = left_smp;
                    right_next = right_smp;
                    bend_next  = block_end;
                end
            end
            ST_COEF_MUL:
            begin
                state_next = ST_COEF;
            end
            ST_COEF:
            begin
                coeff_next = LP_BASE + cf_sum[38:16];
                state_next = ST_ARG_MUL;
            end
            ST_ARG_MUL:
            begin
                state_next = ST_ARG;
            end
            ST_ARG:
            begin
                neg_next   = arg_val[ARG_W-1];
                mag_next   = mag_val;
                state_next = ST_IDX_MUL;
            end
            ST_IDX_MUL:
            begin
                state_next = ST_IDX;
            end
            ST_IDX:
            begin
                // past the last point: hold the end value
                if (idx_full >= IDXF_W'(TANH_TABLE_DEPTH))
                begin
                    idx_next  = IDX_TOP;
                    frac_next = '0;
                end
                else
                begin
                    idx_next  = idx_full[IDX_W-1:0];
                    frac_next = t_val[FRAC_W-1:0];
                end
                state_next = ST_TAB_A;
            end
            ST_TAB_A:
            begin
                state_next = ST_TAB_B;
            end
            ST_TAB_B:
            begin
                a_next     = rom_data;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                diff_next  = $signed({1'b0, rom_data}) - $signed({1'b0, a_reg});
                state_next = ST_INT_MUL;
            end
            ST_INT_MUL:
            begin
                state_next = ST_WET;
            end
            ST_WET:
            begin
                wet_next   = wet_val;
                state_next = ST_LPD;
            end
            ST_LPD:
            begin
                diff_next  = lpd_val;
                state_next = ST_LP_MUL;
            end
            ST_LP_MUL:
            begin
                state_next = ST_LP;
            end
            ST_LP:
            begin
                lp_next[ch_reg] = s_clamp;
                state_next      = ST_DRY_MUL;
            end
            ST_DRY_MUL:
            begin
                state_next = ST_WET_MUL;
            end
            ST_WET_MUL:
            begin
                acc_next   = $signed(prod_reg[ACC_W-1:0]);
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                res_next[ch_reg] = res_val;
                if (ch_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ch_next    = 1'b1;
                    state_next = ST_ARG_MUL;
                end
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= 1'b0;
            lp_reg[0] <= '0;
            lp_reg[1] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            lp_reg    <= lp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        bend_reg  <= bend_next;
        coeff_reg <= coeff_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        idx_reg   <= idx_next;
        frac_reg  <= frac_next;
        a_reg     <= a_next;
        diff_reg  <= diff_next;
        wet_reg   <= wet_next;
        acc_reg   <= acc_next;
    end

    assign stat.idle     = (state_reg == ST_IDLE);
    assign stat.done     = (state_reg == ST_DONE);
    assign left_res      = res_reg[0];
    assign right_res     = res_reg[1];
    assign block_end_res = bend_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDX) |=> (idx_reg <= IDX_TOP))
        else $error("table index past last point");

    a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (start && stat.idle) |=> (state_reg == ST_COEF_MUL && !ch_reg))
        else $error("frame start not taken by sequencer");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX && ch_reg) |=> stat.done)
        else $error("right channel mix did not finish the frame");
`endif

endmodule

### dv/stereo_saturation_lowpass_mix_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the stereo saturator / lowpass / mix block.
module stereo_saturation_lowpass_mix_tb;
    import ssl_pkg::*;

    localparam int SW         = SAMPLE_WIDTH_DEF;
    localparam int TANH_DEPTH = TANH_DEPTH_DEF;

    // fixed-point constants of the signal path
    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint DRIVE_MULT   = 12;
    localparam longint LP_BASE      = 335544;    // 0.02 in Q24
    localparam longint LP_SPAN      = 5872026;   // 0.35 in Q24
    localparam int     FRAC_BITS    = 26;
    localparam longint STATE_MAX    = 8388607;
    localparam longint STATE_MIN    = -8388608;

    // index past the last register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 5;
    localparam int DRAIN_CYCLES  = 40;   // longer than one frame's pass through the sequencer
    localparam int SQUEEZE_LEN   = 300;  // long output hold-off
    localparam int RAND_CHUNKS   = 3;    // config settings per idling regime
    localparam int CHUNK_FRAMES  = 78;

    typedef struct {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic                 blk_end;
    } frame_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [SW-1:0] left_in = '0;
    logic signed [SW-1:0] right_in = '0;
    logic                 block_end_in = 1'b0;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [SW-1:0] left_out;
    logic signed [SW-1:0] right_out;
    logic                 block_end_out;

    // bench-side copy of the register file and the two filter states
    logic [CFG_W-1:0] mix_cfg = MIX_RESET;
    logic [CFG_W-1:0] drive_cfg = DRIVE_RESET;
    logic [CFG_W-1:0] tone_cfg = TONE_RESET;
    longint           left_lp = 0;
    longint           right_lp = 0;
    longint           tanh_q23 [0:TANH_DEPTH];

    frame_t pending_frames [$];
    frame_t expected_mix [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit in_fire = 1'b0;       // input beat taken at the last rising edge
    bit squeeze_req = 1'b0;   // set by stimulus, consumed by the receiver
    bit squeeze_done = 1'b0;
    int hold_left = 0;
    int fail_count = 0;
    int frames_added = 0;     // frames queued by the stimulus
    int frames_seen = 0;      // output beats taken by the monitor

    always #1 clk = ~clk;

    stereo_saturation_lowpass_mix u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .left_in       (left_in),
        .right_in      (right_in),
        .block_end_in  (block_end_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_out      (left_out),
        .right_out     (right_out),
        .block_end_out (block_end_out)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // floor((v + 2^(s-1)) / 2^s): round half up
    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // tanh over [0, 8] in Q1.23: exp(-2u) from a 13-term series of exp(-u/32)
    // squared six times, then (1 - e) / (1 + e)
    task automatic build_tanh_table;
        longint unsigned a, term, sum, den;
        for (int k = 0; k <= TANH_DEPTH; k++)
        begin
            a    = ((longint'(k) << 28) + TANH_DEPTH / 2) / TANH_DEPTH;
            term = Q30;
            sum  = Q30;
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * a) >> 30) / n;
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            for (int n = 0; n < 6; n++)
                sum = (sum * sum + (Q30 >> 1)) >> 30;
            if (sum > Q30)
                sum = Q30;
            den = Q30 + sum;
            tanh_q23[k] = longint'((((Q30 - sum) << 23) + den / 2) / den);
        end
    endtask

    // new lowpass state for one channel: gain, tanh clip, one-pole update
    function automatic longint filter_step(input logic signed [SW-1:0] smp,
                                           input longint filt);
        longint xq, gain, arg, mag, t, idx, frac, y, wet, coeff, s;
        xq   = longint'(smp) * (64'sd1 <<< (24 - SW));
        gain = 65536 + DRIVE_MULT * longint'(drive_cfg);
        arg  = round_shift(xq * gain, 16);
        mag  = (arg < 0) ? -arg : arg;
        t    = mag * TANH_DEPTH;
        idx  = t >>> FRAC_BITS;
        frac = t & ((64'sd1 <<< FRAC_BITS) - 1);
        // beyond 8.0 the curve sits on its last entry
        if (idx >= TANH_DEPTH)
            y = tanh_q23[TANH_DEPTH];
        else
            y = tanh_q23[idx]
                + round_shift((tanh_q23[idx + 1] - tanh_q23[idx]) * frac, FRAC_BITS);
        wet   = (arg < 0) ? -y : y;
        coeff = LP_BASE + ((longint'(tone_cfg) * LP_SPAN + 32768) >>> 16);
        s     = filt + round_shift((wet - filt) * coeff, 24);
        if (s > STATE_MAX)
            s = STATE_MAX;
        if (s < STATE_MIN)
            s = STATE_MIN;
        return s;
    endfunction

    // dry/wet blend of one channel, saturated to the sample range
    function automatic logic signed [SW-1:0] blend_sample(input logic signed [SW-1:0] smp,
                                                          input longint filt);
        longint xq, res;
        xq  = longint'(smp) * (64'sd1 <<< (24 - SW));
        res = round_shift(xq * (65536 - longint'(mix_cfg)) + filt * longint'(mix_cfg),
                          16 + 24 - SW);
        if (res > (64'sd1 <<< (SW - 1)) - 1)
            res = (64'sd1 <<< (SW - 1)) - 1;
        if (res < -(64'sd1 <<< (SW - 1)))
            res = -(64'sd1 <<< (SW - 1));
        return res[SW-1:0];
    endfunction

    task automatic predict_mix(input frame_t f);
        frame_t r;
        left_lp   = filter_step(f.left, left_lp);
        right_lp  = filter_step(f.right, right_lp);
        r.left    = blend_sample(f.left, left_lp);
        r.right   = blend_sample(f.right, right_lp);
        r.blk_end = f.blk_end;
        expected_mix.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                             input logic e);
        frame_t f;
        f.left    = l;
        f.right   = r;
        f.blk_end = e;
        pending_frames.push_back(f);
        frames_added++;
    endtask

    // registers are only touched while nothing is in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_MIX:   mix_cfg = val;
            REG_DRIVE: drive_cfg = val;
            REG_TONE:  tone_cfg = val;
            default:   ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // every queued frame has come back out
    task automatic wait_idle;
        while (frames_seen < frames_added)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // half of the time an extreme, otherwise anything
    function automatic logic [CFG_W-1:0] pick_level();
        case ($urandom_range(7))
            0, 1:    return '0;
            2, 3:    return '1;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // rails, quiet signal near zero, or any code
    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return {1'b0, {(SW-1){1'b1}}};
            1:       return {1'b1, {(SW-1){1'b0}}};
            2, 3:    return SW'(int'($urandom_range(511)) - 256);
            default: return SW'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: next frame goes out at the falling edge once the
    // previous beat was taken; valid never looks at stall
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        frame_t f;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                f = pending_frames.pop_front();
                in_valid     <= 1'b1;
                left_in      <= f.left;
                right_in     <= f.right;
                block_end_in <= f.blk_end;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output receiver: random stall, plus one long hold-off that lets the
    // block fill up and push back on its input
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (squeeze_req && !squeeze_done)
        begin
            squeeze_done = 1'b1;
            hold_left = SQUEEZE_LEN - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Rising edge: take input beats into the predictor, check output beats
    // against the oldest expected frame
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        frame_t f, exp_f;
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
        begin
            f.left    = left_in;
            f.right   = right_in;
            f.blk_end = block_end_in;
            predict_mix(f);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            frames_seen++;
            if (expected_mix.size() == 0)
            begin
                $error("unexpected output beat: left_out %0d right_out %0d block_end_out %0b",
                       left_out, right_out, block_end_out);
                fail_count++;
            end
            else
            begin
                exp_f = expected_mix.pop_front();
                if (left_out !== exp_f.left)
                begin
                    $error("left_out: expected %0d, got %0d", exp_f.left, left_out);
                    fail_count++;
                end
                if (right_out !== exp_f.right)
                begin
                    $error("right_out: expected %0d, got %0d", exp_f.right, right_out);
                    fail_count++;
                end
                if (block_end_out !== exp_f.blk_end)
                begin
                    $error("block_end_out: expected %0b, got %0b", exp_f.blk_end,
                           block_end_out);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        build_tanh_table();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // straight out of reset, registers at their defaults
        add_frame(0, 0, 1'b0);
        add_frame(32767, 32767, 1'b0);
        add_frame(-32768, -32768, 1'b0);
        add_frame(32767, -32768, 1'b1);
        add_frame(-1, 1, 1'b0);
        add_frame(1, -1, 1'b0);
        add_frame(16384, -16384, 1'b0);
        add_frame(-21846, 9000, 1'b1);
        wait_idle();

        // write to the spare index is dropped; then every register at full
        // scale: max drive pushes the tanh argument past the table end,
        // max mix is almost fully wet
        write_reg(REG_UNUSED, '1);
        write_reg(REG_MIX, '1);
        write_reg(REG_DRIVE, '1);
        write_reg(REG_TONE, '1);
        add_frame(32767, -32768, 1'b0);
        add_frame(-32768, 32767, 1'b0);
        add_frame(24000, -24000, 1'b0);
        add_frame(2500, -2500, 1'b0);
        add_frame(0, 0, 1'b1);
        add_frame(32767, 32767, 1'b0);
        add_frame(-32768, -32768, 1'b0);
        add_frame(100, -100, 1'b1);
        wait_idle();

        // all registers at zero: unity gain, slowest filter, fully dry
        write_reg(REG_MIX, '0);
        write_reg(REG_DRIVE, '0);
        write_reg(REG_TONE, '0);
        add_frame(32767, -32768, 1'b0);
        add_frame(-32768, 32767, 1'b1);
        add_frame(12345, -12345, 1'b0);
        add_frame(0, 0, 1'b0);
        add_frame(-1, -1, 1'b0);
        add_frame(1, 1, 1'b1);
        add_frame(32767, 0, 1'b0);
        add_frame(0, -32768, 1'b0);
        wait_idle();

        // random part: three idling regimes, each over several settings
        for (int regime = 0; regime < 3; regime++)
        begin
            case (regime)
                0:
                begin
                    tx_idle_pct = 38;
                    rx_idle_pct = 64;
                end
                1:
                begin
                    tx_idle_pct = 64;
                    rx_idle_pct = 38;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int chunk = 0; chunk < RAND_CHUNKS; chunk++)
            begin
                write_reg(REG_MIX, pick_level());
                write_reg(REG_DRIVE, pick_level());
                write_reg(REG_TONE, pick_level());
                // back-to-back frames against a receiver that goes quiet
                if (regime == 2 && chunk == 0)
                    squeeze_req = 1'b1;
                // blocks of 16 frames, with an odd stray end mark
                for (int i = 0; i < CHUNK_FRAMES; i++)
                    add_frame(pick_sample(), pick_sample(),
                              (i % 16 == 15) || ($urandom_range(19) == 0));
                wait_idle();
            end
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
